// ----- rtl/bpv_pkg.sv -----
// ----------------------------------------------------------------------------
// bpv_pkg
// shared types and constants of the ball projection voxel block
// ----------------------------------------------------------------------------
package bpv_pkg;

    // six complex components, real and imaginary part each
    localparam int FIELD_COUNT  = 12;
    // fields below this index always take part in the norm
    localparam int VECTOR_COUNT = 6;
    localparam int RADIUS_BITS  = 32;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 32'd65536;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TENSOR_MODE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS      = 1'd1;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration as seen by the datapath
    typedef struct packed {
        logic                   tensor_mode;
        logic [RADIUS_BITS-1:0] radius;
    } t_cfg;

endpackage

// ----- rtl/bpv_in_if.sv -----
// ----------------------------------------------------------------------------
// bpv_in_if
// input voxel channel: valid, ready and twelve component fields
// ----------------------------------------------------------------------------
interface bpv_in_if #(parameter int COMP_BITS = 24);
    logic                        valid;
    logic                        ready;
    logic signed [COMP_BITS-1:0] c0_re;
    logic signed [COMP_BITS-1:0] c0_im;
    logic signed [COMP_BITS-1:0] c1_re;
    logic signed [COMP_BITS-1:0] c1_im;
    logic signed [COMP_BITS-1:0] c2_re;
    logic signed [COMP_BITS-1:0] c2_im;
    logic signed [COMP_BITS-1:0] c3_re;
    logic signed [COMP_BITS-1:0] c3_im;
    logic signed [COMP_BITS-1:0] c4_re;
    logic signed [COMP_BITS-1:0] c4_im;
    logic signed [COMP_BITS-1:0] c5_re;
    logic signed [COMP_BITS-1:0] c5_im;

    modport source (output valid, c0_re, c0_im, c1_re, c1_im, c2_re, c2_im,
                    c3_re, c3_im, c4_re, c4_im, c5_re, c5_im, input ready);
    modport sink   (input valid, c0_re, c0_im, c1_re, c1_im, c2_re, c2_im,
                    c3_re, c3_im, c4_re, c4_im, c5_re, c5_im, output ready);
endinterface

// ----- rtl/bpv_out_if.sv -----
// ----------------------------------------------------------------------------
// bpv_out_if
// result voxel channel: valid, ready and twelve projected fields
// ----------------------------------------------------------------------------
interface bpv_out_if #(parameter int COMP_BITS = 24);
    logic                        valid;
    logic                        ready;
    logic signed [COMP_BITS-1:0] o0_re;
    logic signed [COMP_BITS-1:0] o0_im;
    logic signed [COMP_BITS-1:0] o1_re;
    logic signed [COMP_BITS-1:0] o1_im;
    logic signed [COMP_BITS-1:0] o2_re;
    logic signed [COMP_BITS-1:0] o2_im;
    logic signed [COMP_BITS-1:0] o3_re;
    logic signed [COMP_BITS-1:0] o3_im;
    logic signed [COMP_BITS-1:0] o4_re;
    logic signed [COMP_BITS-1:0] o4_im;
    logic signed [COMP_BITS-1:0] o5_re;
    logic signed [COMP_BITS-1:0] o5_im;

    modport source (output valid, o0_re, o0_im, o1_re, o1_im, o2_re, o2_im,
                    o3_re, o3_im, o4_re, o4_im, o5_re, o5_im, input ready);
    modport sink   (input valid, o0_re, o0_im, o1_re, o1_im, o2_re, o2_im,
                    o3_re, o3_im, o4_re, o4_im, o5_re, o5_im, output ready);
endinterface

// ----- rtl/bpv_front.sv -----
// ----------------------------------------------------------------------------
// bpv_front
// squared norm and pipelined integer square root, one bit per stage
// ----------------------------------------------------------------------------
module bpv_front #(
    parameter int COMP_BITS = 24
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  bpv_pkg::t_cfg                               i_cfg,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [bpv_pkg::FIELD_COUNT*COMP_BITS-1:0]   i_item,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [bpv_pkg::FIELD_COUNT*COMP_BITS-1:0]   o_item,
    output logic                                        o_mode,
    output logic [COMP_BITS+1:0]                        o_norm
);
    import bpv_pkg::*;

    localparam int NB  = COMP_BITS + 2;
    localparam int SW  = 2 * NB;
    localparam int SQW = 2 * COMP_BITS;
    localparam int IW  = FIELD_COUNT * COMP_BITS;
    localparam int NS  = NB + 3;

    typedef struct packed {
        logic [NB+1:0]   rem;
        logic [NB-1:0]   root;
        logic [SW-1:0]   s;
        logic            mode;
        logic [IW-1:0]   item;
    } t_sq_stage;

    logic [NS-1:0]    r_v;
    logic [SQW-1:0]   r_a_sq [FIELD_COUNT];
    logic [IW-1:0]    r_a_item;
    logic             r_a_mode;
    logic [SW-1:0]    r_b_g0;
    logic [SW-1:0]    r_b_g1;
    logic [IW-1:0]    r_b_item;
    logic             r_b_mode;
    t_sq_stage        r_st [NB+1];
    t_sq_stage        n_st [NB+1];

    logic             en;
    logic [SQW-1:0]   sq [FIELD_COUNT];
    logic [SW-1:0]    g0;
    logic [SW-1:0]    g1;

    // whole pipe holds while its last stage waits
    assign en      = !r_v[NS-1] || i_ready;
    assign o_ready = en;

    // magnitudes and squares, off-diagonal terms gated by mode
    always_comb begin
        logic [COMP_BITS-1:0] x;
        logic [COMP_BITS-1:0] m;
        for (int i = 0; i < FIELD_COUNT; i++) begin
            x = i_item[i*COMP_BITS +: COMP_BITS];
            m = x[COMP_BITS-1] ? (~x + 1'b1) : x;
            sq[i] = SQW'(m) * SQW'(m);
            if (i >= VECTOR_COUNT && !i_cfg.tensor_mode) begin
                sq[i] = '0;
            end
        end
    end

    // group sums of the squares
    always_comb begin
        g0 = '0;
        g1 = '0;
        for (int i = 0; i < VECTOR_COUNT; i++) begin
            g0 = g0 + SW'(r_a_sq[i]);
            g1 = g1 + SW'(r_a_sq[i+VECTOR_COUNT]);
        end
    end

    // valid shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // square and sum stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
                r_a_sq[i] <= sq[i];
            end
            r_a_item <= i_item;
            r_a_mode <= i_cfg.tensor_mode;
            r_b_g0   <= g0;
            r_b_g1   <= g1;
            r_b_item <= r_a_item;
            r_b_mode <= r_a_mode;
        end
    end

    // load of the root pipeline, off-diagonal sum counts twice
    always_comb begin
        n_st[0].rem  = '0;
        n_st[0].root = '0;
        n_st[0].s    = r_b_g0 + {r_b_g1[SW-2:0], 1'b0};
        n_st[0].mode = r_b_mode;
        n_st[0].item = r_b_item;
    end

    // one root bit per stage
    for (genvar k = 0; k < NB; k++) begin : g_root
        localparam int HI = SW - 1 - 2 * k;
        logic [NB+1:0] remsh;
        logic [NB+1:0] trial;
        always_comb begin
            remsh = {r_st[k].rem[NB-1:0], r_st[k].s[HI -: 2]};
            trial = {r_st[k].root, 2'b01};
            n_st[k+1] = r_st[k];
            if (remsh >= trial) begin
                n_st[k+1].rem  = remsh - trial;
                n_st[k+1].root = {r_st[k].root[NB-2:0], 1'b1};
            end else begin
                n_st[k+1].rem  = remsh;
                n_st[k+1].root = {r_st[k].root[NB-2:0], 1'b0};
            end
        end
    end

    for (genvar k = 0; k <= NB; k++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_item  = r_st[NB].item;
    assign o_mode  = r_st[NB].mode;
    assign o_norm  = r_st[NB].root;

endmodule

// ----- rtl/bpv_queue.sv -----
// ----------------------------------------------------------------------------
// bpv_queue
// short register queue that decouples front and back
// ----------------------------------------------------------------------------
module bpv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    import bpv_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW:0]      r_wp;
    logic [AW:0]      r_rp;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    assign empty   = (r_wp == r_rp);
    assign full    = (r_wp[AW-1:0] == r_rp[AW-1:0]) && (r_wp[AW] != r_rp[AW]);
    assign o_ready = !full;
    assign o_valid = !empty;
    assign push    = i_valid && !full;
    assign pop     = i_ready && !empty;
    assign o_data  = r_mem[r_rp[AW-1:0]];

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end

endmodule

// ----- rtl/bpv_back.sv -----
// ----------------------------------------------------------------------------
// bpv_back
// scaling by radius over norm: twelve pipelined dividers, rounding and select
// ----------------------------------------------------------------------------
module bpv_back #(
    parameter int COMP_BITS = 24
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  bpv_pkg::t_cfg                               i_cfg,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [bpv_pkg::FIELD_COUNT*COMP_BITS-1:0]   i_item,
    input  logic                                        i_mode,
    input  logic [COMP_BITS+1:0]                        i_norm,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [bpv_pkg::FIELD_COUNT*COMP_BITS-1:0]   o_item
);
    import bpv_pkg::*;

    localparam int CB = COMP_BITS;
    localparam int NB = CB + 2;
    localparam int RW = NB + 1;
    localparam int PW = CB + RADIUS_BITS;
    localparam int IW = FIELD_COUNT * CB;
    // compare width covering both the norm and the full radius
    localparam int CW = (NB > RADIUS_BITS) ? NB : RADIUS_BITS;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [CB-1:0] pq;
    } t_lane;

    typedef struct packed {
        logic [IW-1:0]          item;
        logic [FIELD_COUNT-1:0] sel;
        logic [FIELD_COUNT-1:0] neg;
        logic [NB-1:0]          n;
    } t_bk;

    logic [CB:0]   r_bv;
    t_lane         r_ln [CB+1][FIELD_COUNT];
    t_lane         n_ln [CB+1][FIELD_COUNT];
    t_bk           r_bk [CB+1];
    t_bk           n_bk0;
    logic          r_ov;
    logic [IW-1:0] r_out;
    logic [IW-1:0] n_out;
    logic          en;

    // output register frees the pipe whenever it is taken
    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    // entry stage: magnitude times radius, lane selection
    always_comb begin
        logic [CB-1:0] x;
        logic [CB-1:0] m;
        logic [PW-1:0] p;
        logic          proj;
        proj = (CW'(i_norm) > CW'(i_cfg.radius));
        n_bk0.item = i_item;
        n_bk0.n    = i_norm;
        for (int l = 0; l < FIELD_COUNT; l++) begin
            x = i_item[l*CB +: CB];
            m = x[CB-1] ? (~x + 1'b1) : x;
            p = PW'(m) * PW'(i_cfg.radius);
            n_bk0.neg[l]   = x[CB-1];
            n_bk0.sel[l]   = proj && (l < VECTOR_COUNT || i_mode);
            n_ln[0][l].rem = RW'(p >> CB);
            n_ln[0][l].pq  = p[CB-1:0];
        end
    end

    // one quotient bit per stage in each lane
    for (genvar k = 0; k < CB; k++) begin : g_div
        for (genvar l = 0; l < FIELD_COUNT; l++) begin : g_lane
            logic [RW:0] t;
            logic [RW:0] nx;
            logic        ge;
            logic [RW:0] tt;
            always_comb begin
                t  = {r_ln[k][l].rem, r_ln[k][l].pq[CB-1]};
                nx = (RW+1)'(r_bk[k].n);
                ge = (t >= nx);
                tt = ge ? (t - nx) : t;
                n_ln[k+1][l].rem = tt[RW-1:0];
                n_ln[k+1][l].pq  = {r_ln[k][l].pq[CB-2:0], ge};
            end
        end
    end

    // valid shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv <= {r_bv[CB-1:0], i_valid};
            r_ov <= r_bv[CB];
        end
    end

    // divider stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bk[0] <= n_bk0;
            for (int k = 0; k < CB; k++) begin
                r_bk[k+1] <= r_bk[k];
            end
            for (int k = 0; k <= CB; k++) begin
                for (int l = 0; l < FIELD_COUNT; l++) begin
                    r_ln[k][l] <= n_ln[k][l];
                end
            end
            r_out <= n_out;
        end
    end

    // round to nearest, restore sign, pick projected or original
    always_comb begin
        logic [CB-1:0] q;
        logic          up;
        logic [CB-1:0] qr;
        for (int l = 0; l < FIELD_COUNT; l++) begin
            q  = r_ln[CB][l].pq;
            up = ({r_ln[CB][l].rem, 1'b0} >= (RW+1)'(r_bk[CB].n));
            qr = q + CB'(up);
            if (r_bk[CB].sel[l]) begin
                n_out[l*CB +: CB] = r_bk[CB].neg[l] ? (~qr + 1'b1) : qr;
            end else begin
                n_out[l*CB +: CB] = r_bk[CB].item[l*CB +: CB];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

// ----- rtl/l2_ball_projection_voxel.sv -----
// ----------------------------------------------------------------------------
// l2_ball_projection_voxel
// euclidean ball projection of one complex voxel, vector or symmetric tensor
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the output is not held, set by
//   the one-bit-per-stage root and divider pipes; a four-entry queue parts
//   front and back
// reset: synchronous active low, clears control state, radius to 1.0,
//   vector mode
module l2_ball_projection_voxel #(
    parameter int COMP_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpv_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [bpv_pkg::RADIUS_BITS-1:0]     i_cfg_data,
    bpv_in_if.sink                              i_in,
    bpv_out_if.source                           o_out
);
    import bpv_pkg::*;

    localparam int CB  = COMP_BITS;
    localparam int IW  = FIELD_COUNT * CB;
    localparam int EW  = IW + 1 + CB + 2;
    localparam int CAP = (CB + 5) + QUEUE_DEPTH + (CB + 2);
    localparam int KW  = $clog2(CAP + 1);

    t_cfg            r_cfg;
    logic [IW-1:0]   in_item;
    logic            f_valid;
    logic            f_ready;
    logic [IW-1:0]   f_item;
    logic            f_mode;
    logic [CB+1:0]   f_norm;
    logic [EW-1:0]   q_data;
    logic            q_valid;
    logic            q_ready;
    logic [IW-1:0]   b_item;
    logic [KW-1:0]   r_cnt;
    logic            in_acc;
    logic            out_acc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tensor_mode <= 1'b0;
            r_cfg.radius      <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TENSOR_MODE: r_cfg.tensor_mode <= i_cfg_data[0];
                CFG_RADIUS:      r_cfg.radius      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pack the request fields
    assign in_item = {i_in.c5_im, i_in.c5_re, i_in.c4_im, i_in.c4_re,
                      i_in.c3_im, i_in.c3_re, i_in.c2_im, i_in.c2_re,
                      i_in.c1_im, i_in.c1_re, i_in.c0_im, i_in.c0_re};

    bpv_front #(.COMP_BITS(COMP_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item),
        .o_mode  (f_mode),
        .o_norm  (f_norm)
    );

    bpv_queue #(.WIDTH(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_item, f_mode, f_norm}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    bpv_back #(.COMP_BITS(COMP_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_data[EW-1 -: IW]),
        .i_mode  (q_data[CB+2]),
        .i_norm  (q_data[CB+1:0]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (b_item)
    );

    // unpack the result fields
    assign o_out.o0_re = b_item[0*CB +: CB];
    assign o_out.o0_im = b_item[1*CB +: CB];
    assign o_out.o1_re = b_item[2*CB +: CB];
    assign o_out.o1_im = b_item[3*CB +: CB];
    assign o_out.o2_re = b_item[4*CB +: CB];
    assign o_out.o2_im = b_item[5*CB +: CB];
    assign o_out.o3_re = b_item[6*CB +: CB];
    assign o_out.o3_im = b_item[7*CB +: CB];
    assign o_out.o4_re = b_item[8*CB +: CB];
    assign o_out.o4_im = b_item[9*CB +: CB];
    assign o_out.o5_re = b_item[10*CB +: CB];
    assign o_out.o5_im = b_item[11*CB +: CB];

    // requests in flight
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + KW'(in_acc) - KW'(out_acc);
        end
    end

    // occupancy never exceeds the storage of the pipes and queue
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= KW'(CAP))
        else $error("more requests in flight than stages");

    // no result without a request in flight
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_cnt != '0))
        else $error("result with nothing in flight");

    // front stalls only when the queue is full
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in.ready) |-> (f_valid && !f_ready))
        else $error("front stalled without back pressure");

endmodule
